>>> design/chained_hash_table_probe_core_macros.svh
// Assertion helpers for the symbol table core
`ifndef CHAINED_HASH_TABLE_PROBE_CORE_MACROS_SVH
`define CHAINED_HASH_TABLE_PROBE_CORE_MACROS_SVH

// same-cycle implication
`define CHTP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHTP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/chtp_pkg.sv
package chtp_pkg;

  localparam logic [7:0] ASCII_A = 8'd97;
  localparam logic [7:0] LETTERS = 8'd26;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_FIND   = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_BAD_KEY   = 2'd3;

  localparam logic [1:0] ADDR_REPLACE_MODE = 2'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_HEAD,
    S_DISPATCH,
    S_WALK_RD,
    S_WALK_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_TAIL_RD,
    S_TAIL_CHK,
    S_PROBE,
    S_PLACE,
    S_LINK,
    S_HOME,
    S_RESP
  } fsm_e;

endpackage

>>> design/chained_hash_table_probe_core.sv
// Sequence: a bad key or unused action goes straight to the result; otherwise a table scan,
//   a head search, a dispatch, a chain walk (read and check per entry), a free-slot probe,
//   the slot writes (place, link, home) and the result.
// Flow: one transaction at a time, busy outside idle; the next is accepted the cycle after the
//   result. Results are strobed for one cycle; no back-pressure.
// Reset: asynchronous, active low; state, occupancy flags and replace_mode clear at once.
`include "chained_hash_table_probe_core_macros.svh"

module chained_hash_table_probe_core
  import chtp_pkg::*;
#(
  parameter int SLOTS     = 32,
  parameter int KEY_CHARS = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command side
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             action_i,
  input  logic [8*KEY_CHARS-1:0] key_i,
  input  logic [31:0]            attribute_i,
  // result side
  output logic                   valid_o,
  output logic [1:0]             status_o,
  output logic [31:0]            found_attribute_o,
  output logic [4:0]             slot_o,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int KW = 8 * KEY_CHARS;
  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(SLOTS);
  localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS - 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);
  localparam logic [IW:0]   LINK_NIL = '0;

  // Slot storage: key, attribute, link ({valid, index}); one read port, read data registered
  logic [KW-1:0] kmem [SLOTS];
  logic [31:0]   amem [SLOTS];
  logic [IW:0]   lmem [SLOTS];

  logic [KW-1:0] k_rd_q;
  logic [31:0]   a_rd_q;
  logic [IW:0]   l_rd_q;
  logic [IW-1:0] raddr_q;
  logic [IW-1:0] rd_addr;

  logic          data_we, link_we;
  logic [IW-1:0] dw_addr, lw_addr;
  logic [KW-1:0] kw_data;
  logic [31:0]   aw_data;
  logic [IW:0]   lw_data;

  logic          occ_set, occ_clr;
  logic [IW-1:0] set_idx, clr_idx;

  fsm_e state_q, state_d;

  logic             replace_mode_q;
  logic [SLOTS-1:0] occ_q;       // occupied flags
  logic [SLOTS-1:0] haspred_q;   // slot is the target of some link
  logic [SLOTS-1:0] homebit_q;   // slot holds a key of the current home

  // per-transaction working registers
  logic [1:0]    act_q;
  logic [KW-1:0] key_q;
  logic [31:0]   attr_q;
  logic [IW-1:0] h_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] ptr_q, cur_q, wslot_q, lslot_q;
  logic [IW:0]   head_q, prev_q, pred_q;
  logic [KW-1:0] hk_q, pk_q;
  logic [31:0]   ha_q, pa_q;
  logic [IW:0]   hl_q, pl_q;
  logic          repl_q, tail_q;
  logic [1:0]    status_q;
  logic [31:0]   fattr_q;
  logic [4:0]    slot_q;

  logic          accept;
  logic [7:0]    first_c;
  logic          bad_key;
  logic          l_v;
  logic [IW-1:0] l_idx;
  logic          match;
  logic          head_hit;
  logic          full;
  logic          cnt_last;
  logic [IW-1:0] ptr_inc;
  logic          cfg_wr;

  assign accept   = start && !busy;
  assign first_c  = key_i[KW-1 -: 8];
  assign bad_key  = (first_c < ASCII_A) || (first_c >= ASCII_A + LETTERS);
  assign l_v      = l_rd_q[IW];
  assign l_idx    = l_rd_q[IW-1:0];
  assign match    = (k_rd_q == key_q);
  assign head_hit = homebit_q[ptr_q] && !haspred_q[ptr_q];
  assign full     = &occ_q;
  assign cnt_last = (cnt_q == CNT_LAST);
  assign ptr_inc  = (ptr_q == IDX_LAST) ? '0 : ptr_q + 1'b1;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_REPLACE_MODE);
  assign prdata = (paddr == ADDR_REPLACE_MODE) ? {31'd0, replace_mode_q} : 32'd0;

  assign busy              = (state_q != S_IDLE);
  assign valid_o           = (state_q == S_RESP);
  assign status_o          = status_q;
  assign found_attribute_o = fattr_q;
  assign slot_o            = slot_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == ACT_NONE || bad_key) state_d = S_RESP;
          else state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q == CNT_END) state_d = S_HEAD;
      end
      S_HEAD: begin
        if (cnt_q == CNT_END || head_hit) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (act_q != ACT_INSERT) begin
          state_d = head_q[IW] ? S_WALK_RD : S_RESP;
        end else if (!occ_q[h_q]) begin
          state_d = S_PLACE;
        end else if (full) begin
          state_d = S_RESP;
        end else if ((homebit_q[h_q] || !replace_mode_q) && head_q[IW]) begin
          state_d = S_TAIL_RD;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_WALK_RD: state_d = S_WALK_CHK;
      S_WALK_CHK: begin
        if (match) begin
          if (act_q == ACT_DELETE && !prev_q[IW] && l_v) state_d = S_DEL_RD;
          else state_d = S_RESP;
        end else if (!l_v || cnt_last) begin
          state_d = S_RESP;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_DEL_RD: state_d = S_DEL_WR;
      S_DEL_WR: state_d = S_RESP;
      S_TAIL_RD: state_d = S_TAIL_CHK;
      S_TAIL_CHK: begin
        if (!l_v || cnt_last) state_d = S_PROBE;
        else state_d = S_TAIL_RD;
      end
      S_PROBE: begin
        if (!occ_q[ptr_q]) state_d = S_PLACE;
      end
      S_PLACE: begin
        if (repl_q) state_d = pred_q[IW] ? S_LINK : S_HOME;
        else if (tail_q) state_d = S_LINK;
        else state_d = S_RESP;
      end
      S_LINK: state_d = repl_q ? S_HOME : S_RESP;
      S_HOME: state_d = S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory read address and write strobes
  always_comb begin
    rd_addr = '0;
    data_we = 1'b0;
    link_we = 1'b0;
    dw_addr = '0;
    lw_addr = '0;
    kw_data = key_q;
    aw_data = attr_q;
    lw_data = LINK_NIL;
    occ_set = 1'b0;
    occ_clr = 1'b0;
    set_idx = '0;
    clr_idx = '0;
    case (state_q)
      S_SCAN: begin
        if (cnt_q != CNT_END) rd_addr = cnt_q[IW-1:0];
      end
      S_WALK_RD, S_TAIL_RD: rd_addr = cur_q;
      S_DEL_RD: rd_addr = wslot_q;
      S_WALK_CHK: begin
        if (match && act_q == ACT_DELETE) begin
          if (prev_q[IW]) begin
            // unlink from the middle or tail
            link_we = 1'b1;
            lw_addr = prev_q[IW-1:0];
            lw_data = l_rd_q;
            occ_clr = 1'b1;
            clr_idx = cur_q;
          end else if (!l_v) begin
            occ_clr = 1'b1;
            clr_idx = cur_q;
          end
        end
      end
      S_DEL_WR: begin
        // successor moves into the head slot
        data_we = 1'b1;
        dw_addr = cur_q;
        kw_data = k_rd_q;
        aw_data = a_rd_q;
        link_we = 1'b1;
        lw_addr = cur_q;
        lw_data = l_rd_q;
        occ_clr = 1'b1;
        clr_idx = wslot_q;
      end
      S_PLACE: begin
        data_we = 1'b1;
        dw_addr = wslot_q;
        kw_data = pk_q;
        aw_data = pa_q;
        link_we = 1'b1;
        lw_addr = wslot_q;
        lw_data = pl_q;
        occ_set = 1'b1;
        set_idx = wslot_q;
      end
      S_LINK: begin
        link_we = 1'b1;
        lw_addr = lslot_q;
        lw_data = {1'b1, wslot_q};
      end
      S_HOME: begin
        data_we = 1'b1;
        dw_addr = h_q;
        link_we = 1'b1;
        lw_addr = h_q;
        lw_data = head_q;
        occ_set = 1'b1;
        set_idx = h_q;
      end
      default: ;
    endcase
  end

  // slot memories
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      kmem[dw_addr] <= kw_data;
      amem[dw_addr] <= aw_data;
    end
    if (link_we) lmem[lw_addr] <= lw_data;
    k_rd_q  <= kmem[rd_addr];
    a_rd_q  <= amem[rd_addr];
    l_rd_q  <= lmem[rd_addr];
    raddr_q <= rd_addr;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      replace_mode_q <= 1'b0;
      occ_q          <= '0;
      haspred_q      <= '0;
      homebit_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) replace_mode_q <= pwdata[0];
      if (occ_set) occ_q[set_idx] <= 1'b1;
      if (occ_clr) occ_q[clr_idx] <= 1'b0;
      if (accept) begin
        haspred_q <= '0;
        homebit_q <= '0;
      end else if (state_q == S_SCAN && cnt_q != '0) begin
        if (occ_q[raddr_q] && l_v) haspred_q[l_idx] <= 1'b1;
        homebit_q[raddr_q] <= occ_q[raddr_q] &&
                              (k_rd_q[KW-1 -: 8] == ASCII_A + 8'(h_q));
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_q    <= action_i;
          key_q    <= key_i;
          attr_q   <= attribute_i;
          h_q      <= IW'(first_c - ASCII_A);
          cnt_q    <= '0;
          pred_q   <= LINK_NIL;
          fattr_q  <= '0;
          slot_q   <= '0;
          status_q <= (action_i != ACT_NONE && bad_key) ? STAT_BAD_KEY : STAT_NOT_FOUND;
        end
      end
      S_SCAN: begin
        if (cnt_q != '0) begin
          if (occ_q[raddr_q] && l_v && l_idx == h_q) pred_q <= {1'b1, raddr_q};
          if (raddr_q == h_q) begin
            hk_q <= k_rd_q;
            ha_q <= a_rd_q;
            hl_q <= l_rd_q;
          end
        end
        if (cnt_q == CNT_END) begin
          cnt_q  <= '0;
          ptr_q  <= h_q;
          head_q <= LINK_NIL;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      S_HEAD: begin
        if (cnt_q != CNT_END) begin
          if (head_hit) begin
            head_q <= {1'b1, ptr_q};
          end else begin
            ptr_q <= ptr_inc;
            cnt_q <= cnt_q + 1'b1;
          end
        end
      end
      S_DISPATCH: begin
        cnt_q  <= '0;
        cur_q  <= head_q[IW-1:0];
        prev_q <= LINK_NIL;
        repl_q <= 1'b0;
        tail_q <= 1'b0;
        pk_q   <= key_q;
        pa_q   <= attr_q;
        pl_q   <= LINK_NIL;
        ptr_q  <= h_q;
        if (act_q == ACT_INSERT) begin
          if (!occ_q[h_q]) begin
            // free home slot: new key heads the existing chain
            wslot_q  <= h_q;
            pl_q     <= head_q;
            status_q <= STAT_OK;
            slot_q   <= 5'(h_q);
          end else if (full) begin
            status_q <= STAT_FULL;
          end else if (homebit_q[h_q] || !replace_mode_q) begin
            tail_q <= head_q[IW];
          end else begin
            // foreign occupant is moved out
            repl_q  <= 1'b1;
            pk_q    <= hk_q;
            pa_q    <= ha_q;
            pl_q    <= hl_q;
            lslot_q <= pred_q[IW-1:0];
          end
        end
      end
      S_WALK_CHK: begin
        if (match) begin
          status_q <= STAT_OK;
          if (act_q == ACT_FIND) begin
            fattr_q <= a_rd_q;
            slot_q  <= 5'(cur_q);
          end else if (prev_q[IW] || !l_v) begin
            slot_q <= 5'(cur_q);
          end else begin
            wslot_q <= l_idx;
            slot_q  <= 5'(l_idx);
          end
        end else begin
          prev_q <= {1'b1, cur_q};
          cur_q  <= l_idx;
          cnt_q  <= cnt_q + 1'b1;
        end
      end
      S_TAIL_CHK: begin
        if (!l_v) begin
          lslot_q <= cur_q;
          ptr_q   <= cur_q;
        end else if (cnt_last) begin
          lslot_q <= l_idx;
          ptr_q   <= l_idx;
        end else begin
          cur_q <= l_idx;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      S_PROBE: begin
        if (!occ_q[ptr_q]) begin
          wslot_q  <= ptr_q;
          status_q <= STAT_OK;
          slot_q   <= repl_q ? 5'(h_q) : 5'(ptr_q);
        end else begin
          ptr_q <= ptr_inc;
        end
      end
      default: ;
    endcase
  end

  `CHTP_ASSERT_NXT(a_busy_after_start, accept, busy, "transaction accepted but core not busy")
  `CHTP_ASSERT_NXT(a_strobe_single, valid_o, !valid_o, "result strobe longer than one cycle")
  `CHTP_ASSERT_IMP(a_place_free, state_q == S_PLACE, !occ_q[wslot_q],
                   "placing into an occupied slot")
  `CHTP_ASSERT_IMP(a_fail_zero, valid_o && status_o != STAT_OK,
                   slot_o == 5'd0 && found_attribute_o == 32'd0,
                   "failed transaction reports non-zero slot or attribute")

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

// Symbol table core bench: a queue of commands feeds a clocked driver, a clocked
// monitor predicts every accepted transaction and checks each strobed result.
module tb_top;
  import chtp_pkg::*;

  localparam int SLOTS     = 32;
  localparam int KEY_CHARS = 7;
  localparam int KW        = 8 * KEY_CHARS;
  localparam int NO_SLOT   = -1;

  typedef struct {
    logic [1:0]    action;
    logic [KW-1:0] key;
    logic [31:0]   attribute;
  } command_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] found_attribute;
    logic [4:0]  slot;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    action_i = ACT_NONE;
  logic [KW-1:0] key_i = '0;
  logic [31:0]   attribute_i = '0;
  logic          valid_o;
  logic [1:0]    status_o;
  logic [31:0]   found_attribute_o;
  logic [4:0]    slot_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [1:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  chained_hash_table_probe_core #(
    .SLOTS(SLOTS),
    .KEY_CHARS(KEY_CHARS)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .action_i(action_i),
    .key_i(key_i),
    .attribute_i(attribute_i),
    .valid_o(valid_o),
    .status_o(status_o),
    .found_attribute_o(found_attribute_o),
    .slot_o(slot_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the table, kept by the predictor
  logic [KW-1:0] sh_key [SLOTS];
  logic [31:0]   sh_attr[SLOTS];
  int            sh_next[SLOTS];
  bit            sh_used[SLOTS];
  bit            sh_replace;

  command_t cmd_queue[$];
  answer_t  answer_queue[$];
  logic [KW-1:0] known_keys[$];   // latest 64 insert keys with a valid home, for hits on find/delete
  int  fails = 0;
  bit  took = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;

  // Home slot from the first character; NO_SLOT when it is not a lowercase letter
  function automatic int home_of(logic [KW-1:0] k);
    logic [7:0] c;
    c = k[KW-1 -: 8];
    if (c < ASCII_A || c >= ASCII_A + LETTERS) return NO_SLOT;
    return int'(c - ASCII_A);
  endfunction

  function automatic bit is_target(int s);
    for (int q = 0; q < SLOTS; q++)
      if (sh_used[q] && sh_next[q] == s) return 1'b1;
    return 1'b0;
  endfunction

  // Chain head: first slot from the home holding a key of that home with no link into it
  function automatic int chain_head(int h);
    int s;
    for (int d = 0; d < SLOTS; d++) begin
      s = (h + d) % SLOTS;
      if (sh_used[s] && home_of(sh_key[s]) == h && !is_target(s)) return s;
    end
    return NO_SLOT;
  endfunction

  function automatic int chain_tail(int s);
    int cur;
    cur = s;
    for (int n = 0; n < SLOTS && sh_next[cur] != NO_SLOT; n++) cur = sh_next[cur];
    return cur;
  endfunction

  function automatic int free_from(int first);
    int s;
    for (int d = 0; d < SLOTS; d++) begin
      s = (first + d) % SLOTS;
      if (!sh_used[s]) return s;
    end
    return NO_SLOT;
  endfunction

  function automatic void fill(int s, logic [KW-1:0] k, logic [31:0] a, int link);
    sh_key[s]  = k;
    sh_attr[s] = a;
    sh_next[s] = link;
    sh_used[s] = 1'b1;
  endfunction

  function automatic void vacate(int s);
    sh_used[s] = 1'b0;
    sh_next[s] = NO_SLOT;
  endfunction

  function automatic int table_insert(int h, logic [KW-1:0] k, logic [31:0] a);
    int head, f, t, pred;
    head = chain_head(h);
    if (!sh_used[h]) begin
      fill(h, k, a, head);
      return h;
    end
    if (free_from(h) == NO_SLOT) return NO_SLOT;
    if (home_of(sh_key[h]) == h || !sh_replace) begin
      if (head == NO_SLOT) begin
        f = free_from(h);
        fill(f, k, a, NO_SLOT);
        return f;
      end
      t = chain_tail(head);
      f = free_from(t);
      fill(f, k, a, NO_SLOT);
      sh_next[t] = f;
      return f;
    end
    // foreign occupant leaves the home slot, its predecessor relinked
    pred = NO_SLOT;
    for (int q = 0; q < SLOTS; q++)
      if (sh_used[q] && sh_next[q] == h) pred = q;
    f = free_from(h);
    fill(f, sh_key[h], sh_attr[h], sh_next[h]);
    if (pred != NO_SLOT) sh_next[pred] = f;
    fill(h, k, a, head);
    return h;
  endfunction

  function automatic answer_t table_apply(command_t c);
    answer_t r;
    int h, s, prev, cur, hit;
    r.status = STAT_NOT_FOUND;
    r.found_attribute = '0;
    r.slot = '0;
    h = home_of(c.key);
    if (c.action == ACT_NONE) begin
      r.status = STAT_NOT_FOUND;
    end else if (h == NO_SLOT) begin
      r.status = STAT_BAD_KEY;
    end else if (c.action == ACT_INSERT) begin
      s = table_insert(h, c.key, c.attribute);
      if (s == NO_SLOT) begin
        r.status = STAT_FULL;
      end else begin
        r.status = STAT_OK;
        r.slot = s[4:0];
      end
    end else begin
      prev = NO_SLOT;
      hit = NO_SLOT;
      cur = chain_head(h);
      for (int n = 0; n < SLOTS && cur != NO_SLOT; n++) begin
        if (sh_key[cur] == c.key) begin
          hit = cur;
          break;
        end
        prev = cur;
        cur = sh_next[cur];
      end
      if (hit != NO_SLOT) begin
        r.status = STAT_OK;
        if (c.action == ACT_FIND) begin
          r.found_attribute = sh_attr[hit];
          r.slot = hit[4:0];
        end else if (prev != NO_SLOT) begin
          sh_next[prev] = sh_next[hit];
          vacate(hit);
          r.slot = hit[4:0];
        end else if (sh_next[hit] == NO_SLOT) begin
          vacate(hit);
          r.slot = hit[4:0];
        end else begin
          // head removed: its successor moves up into the head slot
          s = sh_next[hit];
          sh_key[hit]  = sh_key[s];
          sh_attr[hit] = sh_attr[s];
          sh_next[hit] = sh_next[s];
          vacate(s);
          r.slot = s[4:0];
        end
      end
    end
    return r;
  endfunction

  // Monitor: predicts on acceptance, checks each strobed result against the oldest
  always @(posedge clk_i) begin
    answer_t want;
    command_t c;
    if (rst_ni) begin
      if (start && !busy) begin
        c.action = action_i;
        c.key = key_i;
        c.attribute = attribute_i;
        answer_queue.push_back(table_apply(c));
        took = 1'b1;
      end
      if (valid_o) begin
        if (answer_queue.size() == 0) begin
          $error("result with nothing expected: status %0d slot %0d", status_o, slot_o);
          fails++;
        end else begin
          want = answer_queue.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fails++;
          end
          if (found_attribute_o !== want.found_attribute) begin
            $error("found_attribute: expected %h, got %h", want.found_attribute,
                   found_attribute_o);
            fails++;
          end
          if (slot_o !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot_o);
            fails++;
          end
        end
      end
    end
  end

  // Driver: holds a command until accepted, sends in bursts with random gaps
  always @(negedge clk_i) begin
    command_t c;
    if (rst_ni && (!start || took)) begin
      took = 1'b0;
      if (gap_left > 0 || cmd_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
      end else begin
        c = cmd_queue.pop_front();
        action_i <= c.action;
        key_i <= c.key;
        attribute_i <= c.attribute;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
  end

  function automatic logic [KW-1:0] make_key(logic [7:0] first, logic [KW-9:0] rest);
    return {first, rest};
  endfunction

  function automatic void push_cmd(logic [1:0] act, logic [KW-1:0] k, logic [31:0] a);
    command_t c;
    c.action = act;
    c.key = k;
    c.attribute = a;
    cmd_queue.push_back(c);
    if (act == ACT_INSERT && home_of(k) != NO_SLOT) begin
      known_keys.push_back(k);
      if (known_keys.size() > 64) void'(known_keys.pop_front());
    end
  endfunction

  // Random tail: mostly from a tiny pool so that keys repeat, sometimes fully random
  function automatic logic [KW-9:0] random_tail();
    logic [KW-9:0] t;
    t = (KW-8)'({$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) t = (KW-8)'({$urandom_range(0, 3), 8'h00});
    return t;
  endfunction

  function automatic void random_cmd(int insert_pct);
    logic [1:0] act;
    logic [KW-1:0] k;
    logic [7:0] first;
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      push_cmd(ACT_NONE, KW'({$urandom, $urandom}), $urandom);
      return;
    end
    if (r < 5) begin
      // first character outside a..z
      first = $urandom_range(0, 1) ? 8'($urandom_range(0, 96)) : 8'($urandom_range(123, 255));
      push_cmd(2'($urandom_range(0, 2)), make_key(first, (KW-8)'({$urandom, $urandom})),
               $urandom);
      return;
    end
    if ($urandom_range(0, 99) < insert_pct) act = ACT_INSERT;
    else act = $urandom_range(0, 1) ? ACT_FIND : ACT_DELETE;
    if (known_keys.size() > 0 && $urandom_range(0, 99) < ((act == ACT_INSERT) ? 20 : 75)) begin
      k = known_keys[$urandom_range(0, known_keys.size() - 1)];
    end else begin
      // bias towards a few neighbouring homes to build long chains and collisions
      first = $urandom_range(0, 1) ? 8'(ASCII_A + $urandom_range(0, 4))
                                   : 8'(ASCII_A + $urandom_range(0, 25));
      k = make_key(first, random_tail());
    end
    push_cmd(act, k, $urandom);
  endfunction

  // Register write over the APB port; only called with the core idle
  task automatic write_mode(bit mode);
    wait (cmd_queue.size() == 0 && !start && answer_queue.size() == 0 && !busy);
    repeat (8) @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ADDR_REPLACE_MODE;
    pwdata = {16'($urandom_range(0, 65535)), 15'h0, mode};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    sh_replace = mode;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    int ins_pct;
    for (int i = 0; i < SLOTS; i++) begin
      sh_next[i] = NO_SLOT;
      sh_used[i] = 1'b0;
    end
    sh_replace = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: chains, duplicates, head/middle delete, misses, bad keys, unused action
    write_mode(1'b0);
    push_cmd(ACT_INSERT, make_key("a", '0), 32'h0000_0000);
    push_cmd(ACT_INSERT, make_key("a", '1), 32'hffff_ffff);
    push_cmd(ACT_INSERT, make_key("a", '0), 32'h1234_5678);   // duplicate key
    push_cmd(ACT_INSERT, make_key("b", 48'h1), 32'h5555_aaaa); // home held by foreign key
    push_cmd(ACT_FIND,   make_key("a", '1), 32'h0);
    push_cmd(ACT_FIND,   make_key("b", 48'h1), 32'h0);
    push_cmd(ACT_FIND,   make_key("c", 48'h9), 32'h0);          // miss, empty chain
    push_cmd(ACT_DELETE, make_key("a", '1), 32'h0);             // middle of chain
    push_cmd(ACT_DELETE, make_key("a", '0), 32'h0);             // head with successor
    push_cmd(ACT_FIND,   make_key("a", '0), 32'h0);
    push_cmd(ACT_INSERT, make_key("z", '1), 32'haaaa_5555);
    push_cmd(ACT_INSERT, make_key("z", '0), 32'h8000_0001);
    push_cmd(ACT_DELETE, make_key("z", '1), 32'h0);             // head with successor
    push_cmd(ACT_INSERT, make_key(8'h60, '1), 32'hffff_ffff);   // just below 'a'
    push_cmd(ACT_FIND,   make_key(8'h7b, '0), 32'h0);           // just above 'z'
    push_cmd(ACT_DELETE, make_key(8'hff, '1), 32'h0);
    push_cmd(ACT_NONE,   make_key("a", '0), 32'hffff_ffff);
    write_mode(1'b1);
    push_cmd(ACT_INSERT, make_key("c", 48'h1), 32'h1);
    push_cmd(ACT_INSERT, make_key("c", 48'h2), 32'h2);          // lands in e's home
    push_cmd(ACT_INSERT, make_key("d", 48'h3), 32'h3);          // displaces b's key from d's home
    push_cmd(ACT_FIND,   make_key("c", 48'h2), 32'h0);
    push_cmd(ACT_DELETE, make_key("c", 48'h1), 32'h0);
    push_cmd(ACT_FIND,   make_key("d", 48'h3), 32'h0);

    // Random phases: alternate fill-heavy and drain-heavy, setting the mode per phase
    for (int p = 0; p < 6; p++) begin
      write_mode(p % 2 == 1 || p == 4);
      ins_pct = (p % 2 == 0) ? 75 : 30;
      for (int n = 0; n < 295; n++) random_cmd(ins_pct);
    end
    write_mode(1'b0);

    wait (cmd_queue.size() == 0 && !start && answer_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fails == 0 && answer_queue.size() == 0) begin
      $display("chained_hash_table_probe_core test passed");
    end else begin
      $display("chained_hash_table_probe_core test failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("chained_hash_table_probe_core test failed");
    $finish;
  end

endmodule
